### rtl/chunky_to_planar_interleaved_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the chunky-to-planar converter
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef CHUNKY_TO_PLANAR_INTERLEAVED_ASSERT_SVH
`define CHUNKY_TO_PLANAR_INTERLEAVED_ASSERT_SVH

// Consequence must hold in the same cycle as the condition.
`define C2PI_ASSERT_NOW(lbl, ck, rstn, cond, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (cond) |-> (cons)) \
    else $error("c2pi check failed");

// Consequence must hold in the cycle after the condition.
`define C2PI_ASSERT_NEXT(lbl, ck, rstn, cond, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (cond) |=> (cons)) \
    else $error("c2pi check failed");

`endif

### rtl/c2pi_pkg.sv
// ---------------------------------------------------------------------------
// c2pi_pkg
// Constants, types and register helpers of the chunky-to-planar converter.
// ---------------------------------------------------------------------------
package c2pi_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int PLANES       = 4;
  localparam int HEIGHT_LIMIT = 4096;

  localparam int LANES      = 8;
  localparam int LANE_IDX_W = $clog2(LANES);
  localparam int PIX_W      = 4;
  localparam int OUT_PLANES = 4;
  localparam int BYTE_W     = 8;
  localparam int OFF_W      = 23;
  localparam int CFG_W      = 13;

  localparam int COL_W    = $clog2((MAX_WIDTH + 7) / 8);
  localparam int ROW_W    = $clog2(HEIGHT_LIMIT);
  localparam int GRP_W    = $clog2((MAX_WIDTH + 7) / 8 + 1);
  localparam int STRIDE_W = $clog2(PLANES * ((MAX_WIDTH + 15) / 16) * 2 + 1);

  localparam int IN_TDATA_W  = LANES * PIX_W;
  localparam int OUT_TDATA_W = ((OUT_PLANES * BYTE_W + OFF_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Register index, taken from the word address.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(320);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(200);

  // Per-item control produced by the sequencer.
  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [OFF_W-1:0] pad_offset;
    logic             pad;
    logic             row_end;
    logic             img_end;
  } item_ctrl_t;

  typedef struct packed {
    logic [OUT_PLANES-1:0][BYTE_W-1:0] planes;
    item_ctrl_t                        ctrl;
  } queue_entry_t;

  // Width clamped to 1..MAX_WIDTH.
  function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] w;
    w = v;
    if (v == '0) w = CFG_W'(1);
    if (v > CFG_W'(MAX_WIDTH)) w = CFG_W'(MAX_WIDTH);
    return w;
  endfunction

  // Height clamped to 1..HEIGHT_LIMIT.
  function automatic logic [CFG_W-1:0] eff_height(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] h;
    h = v;
    if (v == '0) h = CFG_W'(1);
    if (v > CFG_W'(HEIGHT_LIMIT)) h = CFG_W'(HEIGHT_LIMIT);
    return h;
  endfunction

  // Eight-pixel groups in one row.
  function automatic logic [GRP_W-1:0] groups_of(input logic [CFG_W-1:0] w);
    logic [CFG_W:0] s;
    s = {1'b0, w} + (CFG_W + 1)'(7);
    return GRP_W'(s >> 3);
  endfunction

  // Body bytes of one image row: all planes, each padded to a word.
  function automatic logic [STRIDE_W-1:0] stride_of(input logic [CFG_W-1:0] w);
    logic [CFG_W:0] s;
    s = {1'b0, w} + (CFG_W + 1)'(15);
    return STRIDE_W'((s >> 4) * (2 * PLANES));
  endfunction

endpackage

### rtl/c2pi_lane.sv
// ---------------------------------------------------------------------------
// c2pi_lane
// One pixel lane: masks pixels beyond the image width and unused planes.
// ---------------------------------------------------------------------------
module c2pi_lane (
  input  logic [c2pi_pkg::PIX_W-1:0]      pixel,
  input  logic [c2pi_pkg::LANE_IDX_W-1:0] lane_idx,
  input  logic [c2pi_pkg::COL_W-1:0]      col_group,
  input  logic [c2pi_pkg::CFG_W-1:0]      eff_w,
  output logic [c2pi_pkg::OUT_PLANES-1:0] bits
);

  logic [c2pi_pkg::CFG_W+c2pi_pkg::COL_W-1:0] xpos;
  logic                                       in_image;

  // Pixel column of this lane, compared against the image width.
  assign xpos     = (c2pi_pkg::CFG_W + c2pi_pkg::COL_W)'({col_group, lane_idx});
  assign in_image = xpos < (c2pi_pkg::CFG_W + c2pi_pkg::COL_W)'(eff_w);

  // Bit p of the pixel feeds plane p; planes beyond the plane count read zero.
  always_comb begin
    bits = '0;
    for (int p = 0; p < c2pi_pkg::OUT_PLANES; p++) begin
      if (p < c2pi_pkg::PLANES && p < c2pi_pkg::PIX_W) begin
        bits[p] = in_image & pixel[p];
      end
    end
  end

endmodule

### rtl/c2pi_seq.sv
// ---------------------------------------------------------------------------
// c2pi_seq
// Configuration registers and the column, row and row-base counters.
// ---------------------------------------------------------------------------
module c2pi_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  // Register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [c2pi_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [c2pi_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [c2pi_pkg::CFG_DATA_W-1:0]  prdata,
  // Item control
  input  logic                             accept,
  output logic [c2pi_pkg::COL_W-1:0]       col_group,
  output logic [c2pi_pkg::CFG_W-1:0]       eff_w,
  output c2pi_pkg::item_ctrl_t             ctrl
);

  logic [c2pi_pkg::CFG_W-1:0]    width_r, height_r;
  logic [c2pi_pkg::CFG_W-1:0]    eff_w_r, eff_h_r;
  logic [c2pi_pkg::GRP_W-1:0]    groups_r;
  logic [c2pi_pkg::STRIDE_W-1:0] stride_r;

  logic [c2pi_pkg::COL_W-1:0] col_r, col_nxt;
  logic [c2pi_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [c2pi_pkg::OFF_W-1:0] base_r, base_nxt;

  logic                       wr_en;
  logic                       reg_sel;
  logic [c2pi_pkg::CFG_W-1:0] wval;
  logic [c2pi_pkg::GRP_W-1:0] col_inc;
  logic [c2pi_pkg::CFG_W-1:0] row_inc;
  logic                       row_end, img_end;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];
  assign wval    = pwdata[c2pi_pkg::CFG_W-1:0];

  // Register writes; derived limits are worked out from the written value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= c2pi_pkg::WIDTH_RESET;
      height_r <= c2pi_pkg::HEIGHT_RESET;
      eff_w_r  <= c2pi_pkg::eff_width(c2pi_pkg::WIDTH_RESET);
      groups_r <= c2pi_pkg::groups_of(c2pi_pkg::eff_width(c2pi_pkg::WIDTH_RESET));
      stride_r <= c2pi_pkg::stride_of(c2pi_pkg::eff_width(c2pi_pkg::WIDTH_RESET));
      eff_h_r  <= c2pi_pkg::eff_height(c2pi_pkg::HEIGHT_RESET);
    end else if (wr_en) begin
      case (reg_sel)
        c2pi_pkg::REG_WIDTH: begin
          width_r  <= wval;
          eff_w_r  <= c2pi_pkg::eff_width(wval);
          groups_r <= c2pi_pkg::groups_of(c2pi_pkg::eff_width(wval));
          stride_r <= c2pi_pkg::stride_of(c2pi_pkg::eff_width(wval));
        end
        c2pi_pkg::REG_HEIGHT: begin
          height_r <= wval;
          eff_h_r  <= c2pi_pkg::eff_height(wval);
        end
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_sel)
      c2pi_pkg::REG_WIDTH:  prdata = c2pi_pkg::CFG_DATA_W'(width_r);
      c2pi_pkg::REG_HEIGHT: prdata = c2pi_pkg::CFG_DATA_W'(height_r);
      default:              prdata = '0;
    endcase
  end

  // Row and image end detection for the current item.
  assign col_inc = c2pi_pkg::GRP_W'(col_r) + c2pi_pkg::GRP_W'(1);
  assign row_inc = c2pi_pkg::CFG_W'(row_r) + c2pi_pkg::CFG_W'(1);
  assign row_end = col_inc >= groups_r;
  assign img_end = row_end & (row_inc >= eff_h_r);

  always_comb begin
    ctrl.offset     = base_r + c2pi_pkg::OFF_W'(col_r);
    ctrl.pad_offset = base_r + c2pi_pkg::OFF_W'(groups_r);
    ctrl.pad        = row_end & groups_r[0];
    ctrl.row_end    = row_end;
    ctrl.img_end    = img_end;
  end

  assign col_group = col_r;
  assign eff_w     = eff_w_r;

  // Counter advance on each accepted item.
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    base_nxt = base_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        if (img_end) begin
          row_nxt  = '0;
          base_nxt = '0;
        end else begin
          row_nxt  = row_inc[c2pi_pkg::ROW_W-1:0];
          base_nxt = base_r + c2pi_pkg::OFF_W'(stride_r);
        end
      end else begin
        col_nxt = col_inc[c2pi_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      base_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      base_r <= base_nxt;
    end
  end

endmodule

### rtl/c2pi_merge.sv
// ---------------------------------------------------------------------------
// c2pi_merge
// Gathers lane bits into plane bytes and queues results, adding row pads.
// ---------------------------------------------------------------------------
module c2pi_merge (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   push,
  output logic                                                   in_ready,
  input  logic [c2pi_pkg::LANES-1:0][c2pi_pkg::OUT_PLANES-1:0]   lane_bits,
  input  c2pi_pkg::item_ctrl_t                                   ctrl,
  output logic                                                   out_tvalid,
  input  logic                                                   out_tready,
  output logic [c2pi_pkg::OUT_TDATA_W-1:0]                       out_tdata,
  output logic                                                   out_tlast,
  output logic [c2pi_pkg::OUT_TUSER_W-1:0]                       out_tuser
);

  c2pi_pkg::queue_entry_t entry_r [2];
  c2pi_pkg::queue_entry_t new_entry, head;

  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       phase_r, phase_nxt;
  logic       out_fire, pop;
  logic [c2pi_pkg::OUT_PLANES-1:0][c2pi_pkg::BYTE_W-1:0] res_planes;
  logic [c2pi_pkg::OFF_W-1:0] res_offset;

  // Lane b supplies bit 7-b of every plane byte.
  always_comb begin
    new_entry.planes = '0;
    for (int b = 0; b < c2pi_pkg::LANES; b++) begin
      for (int p = 0; p < c2pi_pkg::OUT_PLANES; p++) begin
        new_entry.planes[p][c2pi_pkg::LANES-1-b] = lane_bits[b][p];
      end
    end
    new_entry.ctrl = ctrl;
  end

  // Two-entry item queue; an entry with a pad gives two results.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_entry;
    end
  end

  assign head       = entry_r[rd_ptr_r];
  assign in_ready   = (count_r != 2'd2);
  assign out_tvalid = (count_r != 2'd0);
  assign out_fire   = out_tvalid & out_tready;
  assign pop        = out_fire & (~head.ctrl.pad | phase_r);

  always_comb begin
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
    phase_nxt = phase_r;
    if (out_fire) begin
      phase_nxt = head.ctrl.pad & ~phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
      phase_r  <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Result selection: the group's bytes first, then the zero pad byte.
  always_comb begin
    if (phase_r) begin
      res_planes   = '0;
      res_offset   = head.ctrl.pad_offset;
      out_tlast    = 1'b1;
      out_tuser[0] = 1'b1;
      out_tuser[1] = head.ctrl.img_end;
    end else begin
      res_planes   = head.planes;
      res_offset   = head.ctrl.offset;
      out_tlast    = ~head.ctrl.pad;
      out_tuser[0] = head.ctrl.row_end & ~head.ctrl.pad;
      out_tuser[1] = head.ctrl.img_end & ~head.ctrl.pad;
    end
  end

  assign out_tdata = c2pi_pkg::OUT_TDATA_W'({res_offset, res_planes});

endmodule

### rtl/chunky_to_planar_interleaved.sv
// ---------------------------------------------------------------------------
// chunky_to_planar_interleaved
// Splits eight-pixel groups into bitplane bytes with interleaved body offsets.
// ---------------------------------------------------------------------------
//  Channel  Kind            Contents
//  in_*     stream in       eight 4-bit pixels, one group per item
//  out_*    stream out      four plane bytes and body offset, row/image flags
//  cfg_*    register port   image width (0x0), image height (0x4)
//
// One item is accepted per cycle while the result queue has room; it is
// registered into the queue before its result is offered. A row with an
// odd group count ends with a pad result, sent after the group's result.
// Reset is synchronous: counters return to the first pixel of the image.
// The queue holds two items, so input stays ready while one result waits.
// ---------------------------------------------------------------------------
module chunky_to_planar_interleaved (
  input  logic                               clk,
  input  logic                               rst_n,
  // pixel0 [3:0], pixel1 [7:4], ... pixel7 [31:28]
  input  logic [c2pi_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // plane0_byte [7:0], plane1_byte, plane2_byte, plane3_byte, body_offset [54:32]
  output logic [c2pi_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // end_of_row [0], end_of_image [1]
  output logic [c2pi_pkg::OUT_TUSER_W-1:0]   out_tuser,
  output logic                               out_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [c2pi_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [c2pi_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [c2pi_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  logic                        accept;
  logic [c2pi_pkg::COL_W-1:0]  col_group;
  logic [c2pi_pkg::CFG_W-1:0]  eff_w;
  c2pi_pkg::item_ctrl_t        ctrl;
  logic [c2pi_pkg::LANES-1:0][c2pi_pkg::OUT_PLANES-1:0] lane_bits;

  assign cfg_pready = 1'b1;
  assign accept     = in_tvalid & in_tready;

  // Counters and registers.
  c2pi_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .accept    (accept),
    .col_group (col_group),
    .eff_w     (eff_w),
    .ctrl      (ctrl)
  );

  // One lane per pixel of the group.
  for (genvar i = 0; i < c2pi_pkg::LANES; i++) begin : g_lane
    c2pi_lane u_lane (
      .pixel     (in_tdata[i*c2pi_pkg::PIX_W +: c2pi_pkg::PIX_W]),
      .lane_idx  (c2pi_pkg::LANE_IDX_W'(i)),
      .col_group (col_group),
      .eff_w     (eff_w),
      .bits      (lane_bits[i])
    );
  end

  // Plane byte assembly and result queue.
  c2pi_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .in_ready   (in_tready),
    .lane_bits  (lane_bits),
    .ctrl       (ctrl),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/c2pi_chk.sv
// ---------------------------------------------------------------------------
// c2pi_chk
// Port checker for the converter's result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "chunky_to_planar_interleaved_assert.svh"

module c2pi_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [c2pi_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast,
  input logic [c2pi_pkg::OUT_TUSER_W-1:0] out_tuser
);

  logic group_fire;
  logic pad_shown;

  // A group result taken without closing its item, and a zero pad at row end.
  assign group_fire = out_tvalid && out_tready && !out_tlast;
  assign pad_shown  = out_tvalid && out_tlast && out_tuser[0] && (out_tdata[31:0] == 32'd0);

  // A stalled result stays offered.
  `C2PI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // Image end is always also a row end and the last result of its item.
  `C2PI_ASSERT_NOW(a_eoi_eor, clk, rst_n, out_tvalid && out_tuser[1], out_tuser[0] && out_tlast)

  // Row end always closes its item.
  `C2PI_ASSERT_NOW(a_eor_last, clk, rst_n, out_tvalid && out_tuser[0], out_tlast)

  // A group that does not close its item is followed at once by a zero pad at row end.
  `C2PI_ASSERT_NEXT(a_pad_follows, clk, rst_n, group_fire, pad_shown)

endmodule

bind chunky_to_planar_interleaved c2pi_chk u_c2pi_chk (.*);

### test/testbench.sv
// ---------------------------------------------------------------------------
// Chunky-to-planar converter testbench
// Drives groups of eight pixels through the converter under random source
// and sink stalls, programs image width and height over the register port,
// and checks every result item against script values or an in-bench model
// of the plane split, body offsets, row-end pad and row and image flags.
// ---------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SCRIPT_ROWS = 28;

  // One result item: plane bytes (plane p in byte p), offset and flags.
  typedef struct packed {
    logic [c2pi_pkg::OUT_PLANES-1:0][c2pi_pkg::BYTE_W-1:0] planes;
    logic [c2pi_pkg::OFF_W-1:0]                            offset;
    logic                                                  last_in_run;
    logic                                                  end_of_row;
    logic                                                  end_of_image;
  } planar_result_t;

  // One row of the directed sequence: a register write or a pixel group.
  typedef struct packed {
    logic                            is_cfg;
    logic                            reg_idx;
    logic [c2pi_pkg::CFG_W-1:0]      reg_val;
    logic [c2pi_pkg::IN_TDATA_W-1:0] pixels;
    logic                            typed;
    planar_result_t                  want;
  } script_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic [c2pi_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [c2pi_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [c2pi_pkg::OUT_TUSER_W-1:0] out_tuser;
  logic                             out_tlast;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic                             cfg_psel = 1'b0;
  logic                             cfg_penable = 1'b0;
  logic                             cfg_pwrite = 1'b0;
  logic [c2pi_pkg::CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [c2pi_pkg::CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [c2pi_pkg::CFG_DATA_W-1:0]  cfg_prdata;
  logic                             cfg_pready;

  // Model state and its copy of the registers.
  logic [c2pi_pkg::CFG_W-1:0] width_setting = c2pi_pkg::WIDTH_RESET;
  logic [c2pi_pkg::CFG_W-1:0] height_setting = c2pi_pkg::HEIGHT_RESET;
  int unsigned                col_group = 0;
  int unsigned                row_num = 0;
  int unsigned                row_base_off = 0;

  planar_result_t pending_planes[$];
  int             mismatches = 0;
  int             cycles = 0;
  int             in_idle_pct = 31;
  int             out_idle_pct = 55;

  script_row_t script [SCRIPT_ROWS] = '{
    '{1'b0, 1'b0, 13'd0, 32'hFFFFFFFF, 1'b1, '{32'hFFFFFFFF, 23'd0, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 1'b0, 13'd0, 32'h00000000, 1'b1, '{32'h00000000, 23'd1, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 1'b0, 13'd0, 32'h76543210, 1'b1, '{32'h000F3355, 23'd2, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 1'b0, 13'd0, 32'hFEDCBA98, 1'b1, '{32'hFF0F3355, 23'd3, 1'b1, 1'b0, 1'b0}},
    '{1'b1, c2pi_pkg::REG_WIDTH,  13'd0,    32'h0, 1'b0, '0},
    '{1'b0, 1'b0, 13'd0, 32'hFFFFFFFF, 1'b0, '0},
    '{1'b1, c2pi_pkg::REG_HEIGHT, 13'd1,    32'h0, 1'b0, '0},
    '{1'b0, 1'b0, 13'd0, 32'hFFFFFFFF, 1'b0, '0},
    '{1'b0, 1'b0, 13'd0, 32'h12345678, 1'b0, '0},
    '{1'b1, c2pi_pkg::REG_WIDTH,  13'd9,    32'h0, 1'b0, '0},
    '{1'b1, c2pi_pkg::REG_HEIGHT, 13'd0,    32'h0, 1'b0, '0},
    '{1'b0, 1'b0, 13'd0, 32'hFFFFFFFF, 1'b0, '0},
    '{1'b0, 1'b0, 13'd0, 32'hFFFFFFFF, 1'b0, '0},
    '{1'b1, c2pi_pkg::REG_WIDTH,  13'd8191, 32'h0, 1'b0, '0},
    '{1'b1, c2pi_pkg::REG_HEIGHT, 13'd8191, 32'h0, 1'b0, '0},
    '{1'b0, 1'b0, 13'd0, 32'hA5A5A5A5, 1'b0, '0},
    '{1'b0, 1'b0, 13'd0, 32'h5A5A5A5A, 1'b0, '0},
    '{1'b0, 1'b0, 13'd0, 32'h0F0F0F0F, 1'b0, '0},
    '{1'b1, c2pi_pkg::REG_WIDTH,  13'd4096, 32'h0, 1'b0, '0},
    '{1'b0, 1'b0, 13'd0, 32'hF0F0F0F0, 1'b0, '0},
    '{1'b1, c2pi_pkg::REG_WIDTH,  13'd24,   32'h0, 1'b0, '0},
    '{1'b1, c2pi_pkg::REG_HEIGHT, 13'd2,    32'h0, 1'b0, '0},
    '{1'b0, 1'b0, 13'd0, 32'h89ABCDEF, 1'b0, '0},
    '{1'b0, 1'b0, 13'd0, 32'h01234567, 1'b0, '0},
    '{1'b0, 1'b0, 13'd0, 32'h33CC33CC, 1'b0, '0},
    '{1'b0, 1'b0, 13'd0, 32'hC33CC33C, 1'b0, '0},
    '{1'b0, 1'b0, 13'd0, 32'h7E7E7E7E, 1'b0, '0},
    '{1'b0, 1'b0, 13'd0, 32'h81818181, 1'b0, '0}
  };

  chunky_to_planar_interleaved i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at cycle %0d: %s got 0x%0h, expected 0x%0h", cycles, what, got, want);
    mismatches++;
  endtask

  // Split one pixel group into plane bytes, advance the row and column
  // counters, and queue the result items when keep is set.
  function automatic void split_group(input logic [c2pi_pkg::IN_TDATA_W-1:0] pix,
                                      input bit keep);
    int unsigned                w;
    int unsigned                h;
    int unsigned                row_bytes;
    int unsigned                groups;
    int unsigned                x0;
    logic [c2pi_pkg::PIX_W-1:0] nib;
    bit                         row_end;
    bit                         img_end;
    bit                         pad;
    planar_result_t             res;
    planar_result_t             pad_res;
    w = width_setting;
    if (w == 0) w = 1;
    if (w > c2pi_pkg::MAX_WIDTH) w = c2pi_pkg::MAX_WIDTH;
    h = height_setting;
    if (h == 0) h = 1;
    if (h > c2pi_pkg::HEIGHT_LIMIT) h = c2pi_pkg::HEIGHT_LIMIT;
    row_bytes = ((w + 15) / 16) * 2;
    groups = (w + 7) / 8;
    x0 = col_group * 8;

    // Pixels past the image width contribute no bits.
    res = '0;
    res.offset = c2pi_pkg::OFF_W'(row_base_off + col_group);
    for (int b = 0; b < c2pi_pkg::LANES; b++) begin
      nib = pix[c2pi_pkg::PIX_W*b +: c2pi_pkg::PIX_W];
      if (x0 + b < w) begin
        for (int p = 0; p < c2pi_pkg::OUT_PLANES && p < c2pi_pkg::PLANES; p++) begin
          if (nib[p]) res.planes[p][7-b] = 1'b1;
        end
      end
    end

    col_group++;
    row_end = (col_group >= groups);
    img_end = row_end && (row_num + 1 >= h);
    pad = row_end && (groups % 2 == 1);

    // An odd group count closes the row with a zero pad item.
    if (!pad) begin
      res.last_in_run = 1'b1;
      res.end_of_row = row_end;
      res.end_of_image = img_end;
      if (keep) pending_planes.push_back(res);
    end else begin
      pad_res = '0;
      pad_res.offset = c2pi_pkg::OFF_W'(row_base_off + groups);
      pad_res.last_in_run = 1'b1;
      pad_res.end_of_row = 1'b1;
      pad_res.end_of_image = img_end;
      if (keep) begin
        pending_planes.push_back(res);
        pending_planes.push_back(pad_res);
      end
    end

    if (row_end) begin
      col_group = 0;
      if (img_end) begin
        row_num = 0;
        row_base_off = 0;
      end else begin
        row_num++;
        row_base_off = (row_base_off + c2pi_pkg::PLANES * row_bytes) % (1 << c2pi_pkg::OFF_W);
      end
    end
  endfunction

  // Offer one pixel group after a random gap and wait for its acceptance.
  task automatic send_group(input logic [c2pi_pkg::IN_TDATA_W-1:0] pix, input bit typed,
                            input planar_result_t want);
    int gap;
    gap = 0;
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pix;
    do @(posedge clk); while (!in_tready);
    split_group(pix, !typed);
    if (typed) pending_planes.push_back(want);
  endtask

  // Hold the source until all results have drained, then write a register
  // and read it back.
  task automatic program_reg(input logic idx, input logic [c2pi_pkg::CFG_W-1:0] val);
    logic [c2pi_pkg::CFG_DATA_W-1:0] word;
    word = $urandom();
    word[c2pi_pkg::CFG_W-1:0] = val;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_planes.size() != 0);
    repeat (4) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= c2pi_pkg::CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == c2pi_pkg::REG_WIDTH) width_setting = val;
    else height_setting = val;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== c2pi_pkg::CFG_DATA_W'(val))
      report_mismatch("register readback", cfg_prdata, val);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Sink stalls follow the current idle share.
  always @(posedge clk) begin
    out_tready <= (out_idle_pct == 0) || ($urandom_range(99) >= out_idle_pct);
  end

  // Compare each accepted result item with the oldest pending one.
  always @(posedge clk) begin : result_check
    planar_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_planes.size() == 0) begin
        report_mismatch("unexpected result item", out_tdata, 0);
      end else begin
        exp_res = pending_planes.pop_front();
        for (int p = 0; p < c2pi_pkg::OUT_PLANES; p++) begin
          if (out_tdata[c2pi_pkg::BYTE_W*p +: c2pi_pkg::BYTE_W] !== exp_res.planes[p])
            report_mismatch($sformatf("plane%0d_byte", p),
                            out_tdata[c2pi_pkg::BYTE_W*p +: c2pi_pkg::BYTE_W],
                            exp_res.planes[p]);
        end
        if (out_tdata[c2pi_pkg::OUT_PLANES*c2pi_pkg::BYTE_W +: c2pi_pkg::OFF_W]
            !== exp_res.offset)
          report_mismatch("body_offset",
                          out_tdata[c2pi_pkg::OUT_PLANES*c2pi_pkg::BYTE_W +: c2pi_pkg::OFF_W],
                          exp_res.offset);
        if (out_tlast !== exp_res.last_in_run)
          report_mismatch("last_in_run", out_tlast, exp_res.last_in_run);
        if (out_tuser[0] !== exp_res.end_of_row)
          report_mismatch("end_of_row", out_tuser[0], exp_res.end_of_row);
        if (out_tuser[1] !== exp_res.end_of_image)
          report_mismatch("end_of_image", out_tuser[1], exp_res.end_of_image);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus: directed rows, then random phases with three stall patterns.
  initial begin
    int                              n;
    int                              pause_at;
    int                              pick;
    logic [c2pi_pkg::CFG_W-1:0]      w_val;
    logic [c2pi_pkg::CFG_W-1:0]      h_val;
    logic [c2pi_pkg::IN_TDATA_W-1:0] pix;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) program_reg(script[i].reg_idx, script[i].reg_val);
      else send_group(script[i].pixels, script[i].typed, script[i].want);
    end

    for (int ph = 0; ph < 12; ph++) begin
      case (ph / 4)
        0: begin
          in_idle_pct = 31;
          out_idle_pct = 55;
        end
        1: begin
          in_idle_pct = 55;
          out_idle_pct = 31;
        end
        default: begin
          in_idle_pct = 0;
          out_idle_pct = 0;
        end
      endcase

      // Mostly narrow, short images; one long phase at nearly full width.
      pick = $urandom_range(7);
      case (pick)
        0: w_val = 0;
        1: w_val = $urandom_range(4096, 8191);
        2: w_val = 1;
        default: w_val = $urandom_range(2, 80);
      endcase
      if ($urandom_range(3) == 0) h_val = ($urandom_range(1) == 0) ? 13'd0 : 13'd4096;
      else h_val = $urandom_range(1, 5);
      n = $urandom_range(40, 80);
      if (ph == 5) begin
        w_val = 4088;
        h_val = 2;
        n = 540;
      end
      program_reg(c2pi_pkg::REG_WIDTH, w_val);
      program_reg(c2pi_pkg::REG_HEIGHT, h_val);

      pause_at = $urandom_range(n - 1);
      for (int i = 0; i < n; i++) begin
        // Once per phase, let the result side drain completely.
        if (i == pause_at) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (pending_planes.size() != 0);
        end
        pick = $urandom_range(15);
        if (pick == 0) pix = '0;
        else if (pick == 1) pix = '1;
        else pix = $urandom();
        send_group(pix, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_planes.size() != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
